@@ hdl/kmer_base5_window_encoder_defines.svh @@
// ----------------------------------------------------------------------------
// k-mer encoder assertion macros
// Shared property shorthands for the k-mer encoder, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef KMER_BASE5_WINDOW_ENCODER_DEFINES_SVH
`define KMER_BASE5_WINDOW_ENCODER_DEFINES_SVH

// same-cycle implication
`define KMER5_ASSERT_IMPL(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// next-cycle implication
`define KMER5_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

@@ hdl/kmer5_pkg.sv @@
// ----------------------------------------------------------------------------
// k-mer encoder package
// Field widths, digit codes, control structs and the power-of-five table.
// ----------------------------------------------------------------------------
package kmer5_pkg;

    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 3;
    localparam int KLEN_W   = 5;
    localparam int CODE_W   = 63;
    localparam int BUCKET_W = 5;
    localparam int SUFFIX_W = 59;
    localparam int POW5_LEN = 28;

    typedef logic [CHAR_W-1:0]   char_t;
    typedef logic [DIGIT_W-1:0]  digit_t;
    typedef logic [KLEN_W-1:0]   klen_t;
    typedef logic [CODE_W-1:0]   code_t;
    typedef logic [BUCKET_W-1:0] bucket_t;
    typedef logic [SUFFIX_W-1:0] suffix_t;

    // base digit codes
    localparam digit_t DIGIT_A = 3'd0;
    localparam digit_t DIGIT_C = 3'd1;
    localparam digit_t DIGIT_G = 3'd2;
    localparam digit_t DIGIT_T = 3'd3;
    localparam digit_t DIGIT_N = 3'd4;

    // window step control, shared by the digit line and the code register
    typedef struct packed {
        logic   shift;
        logic   clear;
        digit_t digit;
    } window_ctrl_t;

    // the three oldest digits of the window and the fill status
    typedef struct packed {
        digit_t d0;
        digit_t d1;
        digit_t d2;
        logic   full_after;
    } window_taps_t;

    typedef logic [POW5_LEN-1:0][CODE_W-1:0] pow5_tbl_t;

    function automatic pow5_tbl_t build_pow5();
        pow5_tbl_t tbl;
        tbl[0] = CODE_W'(1);
        for (int i = 1; i < POW5_LEN; i++) begin
            tbl[i] = CODE_W'(tbl[i-1] * CODE_W'(5));
        end
        return tbl;
    endfunction

    // 5^e for e = 0 .. 27, all below 2^63
    localparam pow5_tbl_t POW5 = build_pow5();

    // digit times a power of five, by shifts and adds, modulo 2^63
    function automatic code_t scale_digit(input code_t p, input digit_t d);
        code_t r;
        unique case (d)
            DIGIT_A: r = '0;
            DIGIT_C: r = p;
            DIGIT_G: r = {p[CODE_W-2:0], 1'b0};
            DIGIT_T: r = CODE_W'({p[CODE_W-2:0], 1'b0} + p);
            DIGIT_N: r = {p[CODE_W-3:0], 2'b00};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/kmer5_char_if.sv @@
// ----------------------------------------------------------------------------
// character channel
// Valid/ready channel carrying one sequence character per request.
// ----------------------------------------------------------------------------
interface kmer5_char_if import kmer5_pkg::*; ();
    logic  valid;
    logic  ready;
    char_t base_char;

    modport source (output valid, output base_char, input ready);
    modport sink   (input valid, input base_char, output ready);
endinterface

@@ hdl/kmer5_kmer_if.sv @@
// ----------------------------------------------------------------------------
// k-mer result channel
// Valid/ready channel carrying one encoded k-mer result per request.
// ----------------------------------------------------------------------------
interface kmer5_kmer_if import kmer5_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    kmer_valid;
    code_t   kmer_code;
    bucket_t bucket;
    suffix_t suffix_code;
    logic    bad_char;

    modport source (output valid, output kmer_valid, output kmer_code, output bucket,
                    output suffix_code, output bad_char, input ready);
    modport sink   (input valid, input kmer_valid, input kmer_code, input bucket,
                    input suffix_code, input bad_char, output ready);
endinterface

@@ hdl/kmer_base5_window_encoder.sv @@
// ----------------------------------------------------------------------------
// base-5 k-mer window encoder
// A character request reaches the result through the input register, then the
// result register. Throughput: one character per cycle while kmers.ready does
// not stall the result register, set by the rolling-code update feeding it.
// Reset: window, code and fill count cleared, k-mer length 21 (capped at
// MAX_K); writing the length also empties the window.
// ----------------------------------------------------------------------------
`include "kmer_base5_window_encoder_defines.svh"

module kmer_base5_window_encoder import kmer5_pkg::*; #(
    parameter int MAX_K = 27
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  klen_t         cfg_wr_data,
    kmer5_char_if.sink    chars,
    kmer5_kmer_if.source  kmers
);

    localparam int    KLEN_RESET = 21;
    localparam int    KLEN_MIN   = 3;
    localparam klen_t K_RESET    = KLEN_W'((KLEN_RESET > MAX_K) ? MAX_K : KLEN_RESET);
    localparam klen_t K_MIN      = KLEN_W'(KLEN_MIN);
    localparam klen_t K_MAX      = KLEN_W'(MAX_K);

    // character codes
    localparam char_t CH_NEWLINE = 8'h0A;
    localparam char_t CH_A_UP    = 8'h41;
    localparam char_t CH_C_UP    = 8'h43;
    localparam char_t CH_G_UP    = 8'h47;
    localparam char_t CH_T_UP    = 8'h54;
    localparam char_t CH_N_UP    = 8'h4E;
    localparam char_t CH_A_LO    = 8'h61;
    localparam char_t CH_C_LO    = 8'h63;
    localparam char_t CH_G_LO    = 8'h67;
    localparam char_t CH_T_LO    = 8'h74;
    localparam char_t CH_N_LO    = 8'h6E;

    klen_t        k_eff_reg;
    logic         s1_valid_reg;
    char_t        s1_char_reg;
    logic         out_valid_reg;
    logic         out_kmer_valid_reg;
    code_t        out_code_reg;
    bucket_t      out_bucket_reg;
    suffix_t      out_suffix_reg;
    logic         out_bad_reg;

    logic         res_ready;
    logic         in_ready;
    logic         advance;
    logic         is_base;
    logic         is_newline;
    digit_t       digit;
    window_ctrl_t ctrl;
    window_taps_t taps;
    code_t        code_new;
    bucket_t      bucket;
    suffix_t      suffix;

    // length register, held already clamped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_eff_reg <= K_RESET;
        else if (cfg_wr_en)
        begin
            if (cfg_wr_data < K_MIN)
                k_eff_reg <= K_MIN;
            else if (cfg_wr_data > K_MAX)
                k_eff_reg <= K_MAX;
            else
                k_eff_reg <= cfg_wr_data;
        end
    end

    // handshake: result register parts the two sides
    assign res_ready   = !out_valid_reg || kmers.ready;
    assign in_ready    = !s1_valid_reg || res_ready;
    assign advance     = s1_valid_reg && res_ready;
    assign chars.ready = in_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= chars.valid;
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && in_ready)
            s1_char_reg <= chars.base_char;
    end

    // character to digit
    always_comb
    begin
        is_base    = 1'b1;
        is_newline = 1'b0;
        digit      = DIGIT_A;
        unique case (s1_char_reg)
            CH_A_UP, CH_A_LO: digit = DIGIT_A;
            CH_C_UP, CH_C_LO: digit = DIGIT_C;
            CH_G_UP, CH_G_LO: digit = DIGIT_G;
            CH_T_UP, CH_T_LO: digit = DIGIT_T;
            CH_N_UP, CH_N_LO: digit = DIGIT_N;
            CH_NEWLINE:
            begin
                is_base    = 1'b0;
                is_newline = 1'b1;
            end
            default:          is_base = 1'b0;
        endcase
    end

    // window step control
    assign ctrl.shift = advance && is_base && !cfg_wr_en;
    assign ctrl.clear = cfg_wr_en || (advance && !is_base && !is_newline);
    assign ctrl.digit = digit;

    kmer5_window #(
        .MAX_K (MAX_K)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .k_eff (k_eff_reg),
        .ctrl  (ctrl),
        .taps  (taps)
    );

    kmer5_code u_code (
        .clk      (clk),
        .rst_n    (rst_n),
        .k_eff    (k_eff_reg),
        .ctrl     (ctrl),
        .taps     (taps),
        .code_new (code_new),
        .bucket   (bucket),
        .suffix   (suffix)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_kmer_valid_reg <= is_base && taps.full_after;
            out_code_reg       <= (is_base && taps.full_after) ? code_new : '0;
            out_bucket_reg     <= (is_base && taps.full_after) ? bucket : '0;
            out_suffix_reg     <= (is_base && taps.full_after) ? suffix : '0;
            out_bad_reg        <= !is_base && !is_newline;
        end
    end

    assign kmers.valid       = out_valid_reg;
    assign kmers.kmer_valid  = out_kmer_valid_reg;
    assign kmers.kmer_code   = out_code_reg;
    assign kmers.bucket      = out_bucket_reg;
    assign kmers.suffix_code = out_suffix_reg;
    assign kmers.bad_char    = out_bad_reg;

    // checks
    `KMER5_ASSERT_IMPL(a_kmer_not_bad, kmers.valid && kmers.kmer_valid, !kmers.bad_char,
        "k-mer result flagged as bad character")
    `KMER5_ASSERT_IMPL(a_bucket_range, kmers.valid && kmers.kmer_valid,
        kmers.bucket <= BUCKET_W'(24), "bucket above 24")
    `KMER5_ASSERT_IMPL(a_suffix_le_code, kmers.valid && kmers.kmer_valid,
        CODE_W'(kmers.suffix_code) <= kmers.kmer_code, "suffix code exceeds k-mer code")
    `KMER5_ASSERT_NEXT(a_newline_empty, advance && is_newline,
        kmers.valid && !kmers.kmer_valid && !kmers.bad_char, "newline gave a non-empty result")

endmodule

@@ hdl/kmer5_window.sv @@
// ----------------------------------------------------------------------------
// digit window
// Variable-length shift line of base digits: a new digit enters at cell k-1,
// older digits move towards cell 0, so cells 0..2 always hold the oldest
// three digits of the current window. Also tracks the fill count.
// ----------------------------------------------------------------------------
module kmer5_window import kmer5_pkg::*; #(
    parameter int MAX_K = 27
) (
    input  logic         clk,
    input  logic         rst_n,
    input  klen_t        k_eff,
    input  window_ctrl_t ctrl,
    output window_taps_t taps
);

    digit_t cell_reg  [MAX_K];
    digit_t cell_next [MAX_K];
    klen_t  fill_reg;
    klen_t  fill_next;
    klen_t  entry_pos;

    assign entry_pos = KLEN_W'(k_eff - KLEN_W'(1));

    // next value of each cell
    for (genvar i = 0; i < MAX_K; i++) begin : g_cell
        if (i < MAX_K - 1) begin : g_mid
            always_comb
            begin
                if (ctrl.clear)
                    cell_next[i] = '0;
                else if (ctrl.shift)
                    cell_next[i] = (entry_pos == KLEN_W'(i)) ? ctrl.digit : cell_reg[i+1];
                else
                    cell_next[i] = cell_reg[i];
            end
        end else begin : g_last
            always_comb
            begin
                if (ctrl.clear)
                    cell_next[i] = '0;
                else if (ctrl.shift && (entry_pos == KLEN_W'(i)))
                    cell_next[i] = ctrl.digit;
                else
                    cell_next[i] = cell_reg[i];
            end
        end
    end

    // saturating fill count
    always_comb
    begin
        if (ctrl.clear)
            fill_next = '0;
        else if (ctrl.shift && (fill_reg < k_eff))
            fill_next = KLEN_W'(fill_reg + KLEN_W'(1));
        else
            fill_next = fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_K; i++) begin
                cell_reg[i] <= '0;
            end
            fill_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < MAX_K; i++) begin
                cell_reg[i] <= cell_next[i];
            end
            fill_reg <= fill_next;
        end
    end

    // oldest digits and whether one more digit completes the window
    assign taps.d0         = cell_reg[0];
    assign taps.d1         = cell_reg[1];
    assign taps.d2         = cell_reg[2];
    assign taps.full_after = (fill_reg >= entry_pos);

endmodule

@@ hdl/kmer5_code.sv @@
// ----------------------------------------------------------------------------
// rolling code unit
// Holds the base-5 code of the window and derives the next code, the bucket
// and the suffix code. Arithmetic wraps at 63 bits; every true result lies
// below 5^27 < 2^63, so the wrapped value is exact.
// ----------------------------------------------------------------------------
module kmer5_code import kmer5_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  klen_t        k_eff,
    input  window_ctrl_t ctrl,
    input  window_taps_t taps,
    output code_t        code_new,
    output bucket_t      bucket,
    output suffix_t      suffix
);

    code_t code_reg;
    code_t code_next;
    code_t code_base;
    code_t drop0;
    code_t drop1;
    code_t drop2;
    klen_t k_m1;
    klen_t k_m2;

    assign k_m1 = KLEN_W'(k_eff - KLEN_W'(1));
    assign k_m2 = KLEN_W'(k_eff - KLEN_W'(2));

    // oldest digit leaves, the rest move up one place, new digit enters
    assign code_base = CODE_W'({code_reg, 2'b00} + {2'b00, code_reg}
                               + (CODE_W + 2)'(ctrl.digit));
    assign drop0     = scale_digit(POW5[k_eff], taps.d0);
    assign code_new  = CODE_W'(code_base - drop0);

    // leading two digits of the new window are the old second and third
    assign drop1  = scale_digit(POW5[k_m1], taps.d1);
    assign drop2  = scale_digit(POW5[k_m2], taps.d2);
    assign suffix = SUFFIX_W'(code_new - drop1 - drop2);
    assign bucket = BUCKET_W'(BUCKET_W'(taps.d1) * BUCKET_W'(5) + BUCKET_W'(taps.d2));

    // code register update
    always_comb
    begin
        if (ctrl.clear)
            code_next = '0;
        else if (ctrl.shift)
            code_next = code_new;
        else
            code_next = code_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            code_reg <= '0;
        else
            code_reg <= code_next;
    end

endmodule
